### hw/rtl/tat_pkg.sv
// ----------------------------------------------------------------------------
// tat_pkg
// Types and constants shared by the three-anchor trilateration block.
// ----------------------------------------------------------------------------
package tat_pkg;

	// Field widths
	localparam int CW  = 32;   // Q16.16 coordinate
	localparam int DW  = 33;   // anchor difference or sum
	localparam int PW  = 66;   // product of two differences
	localparam int DTW = 67;   // determinant
	localparam int LW  = 68;   // right-hand side of a radical-axis equation
	localparam int NW  = 102;  // Cramer numerator
	localparam int DNW = 68;   // denominator magnitude
	localparam int QW  = 31;   // unsaturated quotient bits
	localparam int MDW = 63;   // min_determinant register

	localparam logic [MDW-1:0] MIN_DET_RESET = 63'd4294967;
	localparam logic [CW-1:0]  ERR_COORD     = 32'hFFFF_0000;
	localparam logic [CW-1:0]  SAT_POS       = 32'h7FFF_FFFF;
	localparam logic [CW-1:0]  SAT_NEG       = 32'h8000_0000;

	// Status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_NEG = 2'd1;
	localparam logic [1:0] ST_COL = 2'd2;

	typedef struct packed {
		logic signed [CW-1:0] anchor_a_x;
		logic signed [CW-1:0] anchor_a_y;
		logic signed [CW-1:0] anchor_b_x;
		logic signed [CW-1:0] anchor_b_y;
		logic signed [CW-1:0] anchor_c_x;
		logic signed [CW-1:0] anchor_c_y;
		logic signed [CW-1:0] range_a;
		logic signed [CW-1:0] range_b;
		logic signed [CW-1:0] range_c;
	} item_t;

	typedef struct packed {
		logic signed [CW-1:0] pos_x;
		logic signed [CW-1:0] pos_y;
		logic [1:0]           status;
	} result_t;

	// Classified item handed from the front part to the back part
	typedef struct packed {
		logic [1:0]            status;
		logic signed [DTW-1:0] det;
		logic signed [LW-1:0]  l1;
		logic signed [LW-1:0]  l2;
		logic signed [DW-1:0]  a1;
		logic signed [DW-1:0]  b1;
		logic signed [DW-1:0]  a2;
		logic signed [DW-1:0]  b2;
	} mid_t;

endpackage

### hw/rtl/tat_fifo.sv
// ----------------------------------------------------------------------------
// tat_fifo
// Two-entry register queue with count-based full and empty flags.
// ----------------------------------------------------------------------------
module tat_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         do_wr;
	logic         do_rd;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// store written items
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### hw/rtl/tat_front.sv
// ----------------------------------------------------------------------------
// tat_front
// Front part: forms differences, determinant and equation right-hand sides,
// then classifies each item as ok, negative range or collinear anchors.
// ----------------------------------------------------------------------------
module tat_front import tat_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  item_t            in_item,
	output logic             adv,
	input  logic [MDW-1:0]   min_det,
	output logic             out_push,
	output mid_t             out_data,
	input  logic             out_full
);

	logic [3:0] vld_s;

	// stage 1: differences and sums
	logic                    neg_s1;
	logic signed [DW-1:0]    a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [DW-1:0]    sbx_s1, sby_s1, scx_s1, scy_s1;
	logic signed [DW-1:0]    dab_s1, sab_s1, dac_s1, sac_s1;
	// stage 2: products
	logic                    neg_s2;
	logic signed [DW-1:0]    a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [PW-1:0]    pd1_s2, pd2_s2;
	logic signed [PW-1:0]    pr1_s2, px1_s2, py1_s2, pr2_s2, px2_s2, py2_s2;
	// stage 3: determinant and right-hand sides, negative range in status
	mid_t                    mid_s3;
	// stage 4: classified item
	mid_t                    mid_s4;
	logic [DTW-1:0]          adet;
	mid_t                    cls;

	assign adv      = !(vld_s[3] && out_full);
	assign out_push = vld_s[3] && !out_full;
	assign out_data = mid_s4;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[2:0], in_valid};
		end
	end

	// form differences and sums
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1 <= in_item.range_a[CW-1] || in_item.range_b[CW-1] ||
				in_item.range_c[CW-1];
			a1_s1  <= DW'(in_item.anchor_b_x) - DW'(in_item.anchor_a_x);
			b1_s1  <= DW'(in_item.anchor_b_y) - DW'(in_item.anchor_a_y);
			a2_s1  <= DW'(in_item.anchor_c_x) - DW'(in_item.anchor_a_x);
			b2_s1  <= DW'(in_item.anchor_c_y) - DW'(in_item.anchor_a_y);
			sbx_s1 <= DW'(in_item.anchor_b_x) + DW'(in_item.anchor_a_x);
			sby_s1 <= DW'(in_item.anchor_b_y) + DW'(in_item.anchor_a_y);
			scx_s1 <= DW'(in_item.anchor_c_x) + DW'(in_item.anchor_a_x);
			scy_s1 <= DW'(in_item.anchor_c_y) + DW'(in_item.anchor_a_y);
			dab_s1 <= DW'(in_item.range_a) - DW'(in_item.range_b);
			sab_s1 <= DW'(in_item.range_a) + DW'(in_item.range_b);
			dac_s1 <= DW'(in_item.range_a) - DW'(in_item.range_c);
			sac_s1 <= DW'(in_item.range_a) + DW'(in_item.range_c);
		end
	end

	// multiply
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2 <= neg_s1;
			a1_s2  <= a1_s1;
			b1_s2  <= b1_s1;
			a2_s2  <= a2_s1;
			b2_s2  <= b2_s1;
			pd1_s2 <= a1_s1 * b2_s1;
			pd2_s2 <= a2_s1 * b1_s1;
			pr1_s2 <= dab_s1 * sab_s1;
			px1_s2 <= a1_s1 * sbx_s1;
			py1_s2 <= b1_s1 * sby_s1;
			pr2_s2 <= dac_s1 * sac_s1;
			px2_s2 <= a2_s1 * scx_s1;
			py2_s2 <= b2_s1 * scy_s1;
		end
	end

	// sum into determinant and right-hand sides
	always_ff @(posedge clk) begin
		if (adv) begin
			mid_s3.status <= neg_s2 ? ST_NEG : ST_OK;
			mid_s3.det    <= DTW'(pd1_s2) - DTW'(pd2_s2);
			mid_s3.l1     <= LW'(pr1_s2) + LW'(px1_s2) + LW'(py1_s2);
			mid_s3.l2     <= LW'(pr2_s2) + LW'(px2_s2) + LW'(py2_s2);
			mid_s3.a1     <= a1_s2;
			mid_s3.b1     <= b1_s2;
			mid_s3.a2     <= a2_s2;
			mid_s3.b2     <= b2_s2;
		end
	end

	assign adet = mid_s3.det[DTW-1] ? DTW'(-mid_s3.det) : DTW'(mid_s3.det);

	// classify: negative range first, then collinear anchors
	always_comb begin
		cls = mid_s3;
		if (mid_s3.status == ST_NEG) begin
			cls.status = ST_NEG;
		end else if (adet == '0 || adet < DTW'(min_det)) begin
			cls.status = ST_COL;
		end else begin
			cls.status = ST_OK;
		end
	end

	// hold the classified item
	always_ff @(posedge clk) begin
		if (adv) begin
			mid_s4 <= cls;
		end
	end

endmodule

### hw/rtl/tat_div.sv
// ----------------------------------------------------------------------------
// tat_div
// Pipelined restoring divider: a seed stage, then one quotient bit per stage.
// Flags a quotient of 2^31 or more as saturated.
// ----------------------------------------------------------------------------
module tat_div import tat_pkg::*; (
	input  logic            clk,
	input  logic            adv,
	input  logic [NW-1:0]   num,
	input  logic [DNW-1:0]  den,
	input  logic            neg,
	output logic [QW-1:0]   quo,
	output logic            sat,
	output logic            quo_neg
);

	logic [DNW-1:0] rem_s  [QW+1];
	logic [QW-1:0]  low_s  [QW+1];
	logic [QW-1:0]  quo_s  [QW+1];
	logic [DNW-1:0] den_s  [QW+1];
	logic           sat_s  [QW+1];
	logic           neg_s  [QW+1];

	// check saturation, seed remainder with the high numerator bits
	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s[0] <= num[NW-1:QW] >= (NW-QW)'(den);
			rem_s[0] <= num[QW+DNW-1:QW];
			low_s[0] <= num[QW-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DNW:0] trial;
		logic [DNW:0] diff;
		logic         ge;

		assign trial = {rem_s[k], low_s[k][QW-1]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign ge    = trial >= {1'b0, den_s[k]};

		// subtract where it fits, shift in a quotient bit
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= ge ? diff[DNW-1:0] : trial[DNW-1:0];
				low_s[k+1] <= {low_s[k][QW-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
				den_s[k+1] <= den_s[k];
				sat_s[k+1] <= sat_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign quo     = quo_s[QW];
	assign sat     = sat_s[QW];
	assign quo_neg = neg_s[QW];

endmodule

### hw/rtl/tat_back.sv
// ----------------------------------------------------------------------------
// tat_back
// Back part: Cramer numerators, two pipelined divisions, saturation and
// error coding of each result.
// ----------------------------------------------------------------------------
module tat_back import tat_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  mid_t     in_data,
	output logic     adv,
	output logic     out_push,
	output result_t  out_data,
	input  logic     out_full
);

	localparam int DL = QW + 1;     // divider latency
	localparam int BL = 4 + DL + 1; // total stages
	localparam int HS = 34;         // split point of the wide operand

	logic [BL-1:0] vld_s;

	// stage 1: partial products
	logic signed [HS+DW-1:0]   ph_s1 [4];
	logic signed [HS+DW+1:0]   pl_s1 [4];
	logic signed [LW-1:0]      den_s1;
	// stage 2: full products
	logic signed [NW-1:0]      prod_s2 [4];
	logic signed [LW-1:0]      den_s2;
	// stage 3: numerators
	logic signed [NW-1:0]      nx_s3, ny_s3;
	logic signed [LW-1:0]      den_s3;
	// stage 4: magnitudes and signs
	logic [NW-1:0]             nxm_s4, nym_s4;
	logic [DNW-1:0]            dm_s4;
	logic                      negx_s4, negy_s4;
	// status travels beside the data
	logic [1:0]                st_s [4+DL];
	// divider outputs
	logic [QW-1:0]             qx, qy;
	logic                      satx, saty, qnegx, qnegy;
	result_t                   res_s;

	logic signed [LW-1:0]      lsel [4];
	logic signed [DW-1:0]      msel [4];

	assign adv      = !(vld_s[BL-1] && out_full);
	assign out_push = vld_s[BL-1] && !out_full;
	assign out_data = res_s;

	// operand pairs: l1*b2, l2*b1, l2*a1, l1*a2
	assign lsel[0] = in_data.l1;
	assign msel[0] = in_data.b2;
	assign lsel[1] = in_data.l2;
	assign msel[1] = in_data.b1;
	assign lsel[2] = in_data.l2;
	assign msel[2] = in_data.a1;
	assign lsel[3] = in_data.l1;
	assign msel[3] = in_data.a2;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[BL-2:0], in_valid};
		end
	end

	// carry status alongside
	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0] <= in_data.status;
			for (int i = 1; i < 4 + DL; i++) begin
				st_s[i] <= st_s[i-1];
			end
		end
	end

	// split each wide operand into high and low halves and multiply
	for (genvar k = 0; k < 4; k++) begin : g_mul
		always_ff @(posedge clk) begin
			if (adv) begin
				ph_s1[k] <= $signed(lsel[k][LW-1:HS]) * msel[k];
				pl_s1[k] <= $signed({1'b0, lsel[k][HS-1:0]}) * msel[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s2[k] <= (NW'(ph_s1[k]) <<< HS) + NW'(pl_s1[k]);
			end
		end
	end

	// combine into numerators
	always_ff @(posedge clk) begin
		if (adv) begin
			den_s1 <= LW'(in_data.det) <<< 1;
			den_s2 <= den_s1;
			den_s3 <= den_s2;
			nx_s3  <= prod_s2[0] - prod_s2[1];
			ny_s3  <= prod_s2[2] - prod_s2[3];
		end
	end

	// take magnitudes and quotient signs
	always_ff @(posedge clk) begin
		if (adv) begin
			nxm_s4  <= nx_s3[NW-1] ? NW'(-nx_s3) : NW'(nx_s3);
			nym_s4  <= ny_s3[NW-1] ? NW'(-ny_s3) : NW'(ny_s3);
			dm_s4   <= den_s3[LW-1] ? DNW'(-den_s3) : DNW'(den_s3);
			negx_s4 <= nx_s3[NW-1] ^ den_s3[LW-1];
			negy_s4 <= ny_s3[NW-1] ^ den_s3[LW-1];
		end
	end

	tat_div u_div_x (
		.clk     (clk),
		.adv     (adv),
		.num     (nxm_s4),
		.den     (dm_s4),
		.neg     (negx_s4),
		.quo     (qx),
		.sat     (satx),
		.quo_neg (qnegx)
	);

	tat_div u_div_y (
		.clk     (clk),
		.adv     (adv),
		.num     (nym_s4),
		.den     (dm_s4),
		.neg     (negy_s4),
		.quo     (qy),
		.sat     (saty),
		.quo_neg (qnegy)
	);

	function automatic logic [CW-1:0] to_coord(input logic s, input logic n,
		input logic [QW-1:0] q);
		logic [CW-1:0] m;
		m = {1'b0, q};
		if (s) begin
			return n ? SAT_NEG : SAT_POS;
		end
		return n ? CW'(-m) : m;
	endfunction

	// saturate, sign and code errors
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s.status <= st_s[3+DL];
			if (st_s[3+DL] != ST_OK) begin
				res_s.pos_x <= ERR_COORD;
				res_s.pos_y <= ERR_COORD;
			end else begin
				res_s.pos_x <= to_coord(satx, qnegx, qx);
				res_s.pos_y <= to_coord(saty, qnegy, qy);
			end
		end
	end

endmodule

### hw/rtl/three_anchor_trilateration.sv
// ----------------------------------------------------------------------------
// three_anchor_trilateration
// Radical center of three range circles, Q16.16 in and out, by Cramer's rule
// with a pipelined division.
//
//   channel   direction  handshake          payload
//   item      in         push / full        item_t (anchors, ranges)
//   result    out        pop / empty        result_t (pos_x, pos_y, status)
//   config    in         APB psel/penable   min_determinant at byte 0
//
// One item per cycle sustained while no queue fills. On its way to the result
// queue an item passes 4 front stages (the first at the accepting edge), a write
// into the middle queue, 4 numerator stages, 32 divider stages (seed plus one
// quotient bit each), one output stage and a write into the result queue.
// Front and back stall independently on their full queues.
// Reset clears all valid bits and queues; min_determinant returns to 1e-3.
// ----------------------------------------------------------------------------
module three_anchor_trilateration import tat_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  item_t        item,
	output logic         full,
	input  logic         pop,
	output result_t      result,
	output logic         empty,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	logic [MDW-1:0] min_det_q;
	logic           front_adv;
	logic           mid_push, mid_full, mid_empty, mid_pop;
	mid_t           mid_wdata, mid_rdata;
	logic           back_adv;
	logic           res_push, res_full;
	result_t        res_wdata;

	assign pready = 1'b1;
	assign prdata = paddr[3] ? 64'd0 : {1'b0, min_det_q};

	// write the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_det_q <= MIN_DET_RESET;
		end else if (psel && penable && pwrite && !paddr[3]) begin
			min_det_q <= pwdata[MDW-1:0];
		end
	end

	assign full = !front_adv;

	tat_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push && front_adv),
		.in_item  (item),
		.adv      (front_adv),
		.min_det  (min_det_q),
		.out_push (mid_push),
		.out_data (mid_wdata),
		.out_full (mid_full)
	);

	tat_fifo #(.W($bits(mid_t))) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_wdata),
		.full    (mid_full),
		.rd_en   (mid_pop),
		.rd_data (mid_rdata),
		.empty   (mid_empty)
	);

	assign mid_pop = back_adv && !mid_empty;

	tat_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mid_pop),
		.in_data  (mid_rdata),
		.adv      (back_adv),
		.out_push (res_push),
		.out_data (res_wdata),
		.out_full (res_full)
	);

	tat_fifo #(.W($bits(result_t))) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_wdata),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule

### hw/rtl/tat_checker.sv
// ----------------------------------------------------------------------------
// tat_checker
// Port-level checks on the result channel of the trilateration block.
// ----------------------------------------------------------------------------
module tat_checker import tat_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pop,
	input  logic     empty,
	input  result_t  result
);

	// status is one of the three defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.status == ST_OK || result.status == ST_NEG ||
		result.status == ST_COL))
		else $error("undefined status code");

	// an error result carries -1.0 in both coordinates
	a_err_coord: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != ST_OK) |->
		(result.pos_x == ERR_COORD && result.pos_y == ERR_COORD))
		else $error("error result without -1.0 coordinates");

	// a waiting result stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result dropped or changed before pop");

endmodule

bind three_anchor_trilateration tat_checker u_tat_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.pop    (pop),
	.empty  (empty),
	.result (result)
);
